// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL; clock is clk, reset is arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/rsw_pkg.sv -----
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared types and codes of the register scoreboard wakeup block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsw_pkg;

	localparam int MaskW = 64;
	localparam int IdW   = 16;
	localparam int UnitW = 2;
	localparam int ModeW = 3;
	localparam int KindW = 2;
	localparam int CfgIdxW = 8;

	localparam logic [ModeW-1:0] MODE_TICK   = 3'd0;
	localparam logic [ModeW-1:0] MODE_PROD   = 3'd1;
	localparam logic [ModeW-1:0] MODE_BCAST  = 3'd2;
	localparam logic [ModeW-1:0] MODE_CLEAR  = 3'd3;
	localparam logic [ModeW-1:0] MODE_ADD    = 3'd4;
	localparam logic [ModeW-1:0] MODE_CANCEL = 3'd5;

	localparam logic [KindW-1:0] KIND_WAKE  = 2'd0;
	localparam logic [KindW-1:0] KIND_WFULL = 2'd1;
	localparam logic [KindW-1:0] KIND_PFULL = 2'd2;

	localparam logic [7:0] LAT_NONE = 8'hFF;
	localparam logic [7:0] LAT_NOW  = 8'h00;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [UnitW-1:0] view;
		logic [IdW-1:0]   id;
		logic [MaskW-1:0] mask;
	} res_t;

	typedef struct packed {
		logic load;
		logic shift;
	} wcell_ctl_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic age;
	} pcell_ctl_t;

endpackage

`default_nettype wire

// ----- src/rsw_wcell.sv -----
// ----------------------------------------------------------------------------
// rsw_wcell
// One waiter slot: needed mask and id; loads a new waiter or takes its
// upper neighbor's entry when it or a slot below is removed.
// ----------------------------------------------------------------------------
`default_nettype none

module rsw_wcell #(
	parameter int MW = 64
) (
	input  wire logic                clk,
	input  wire rsw_pkg::wcell_ctl_t ctl,
	input  wire logic [MW-1:0]       nxt_need,
	input  wire logic [15:0]         nxt_id,
	input  wire logic [MW-1:0]       new_need,
	input  wire logic [15:0]         new_id,
	output logic      [MW-1:0]       need,
	output logic      [15:0]         id
);

	logic [MW-1:0] need_q;
	logic [15:0]   id_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			need_q <= new_need;
			id_q   <= new_id;
		end else if (ctl.shift) begin
			need_q <= nxt_need;
			id_q   <= nxt_id;
		end
	end

	assign need = need_q;
	assign id   = id_q;

endmodule

`default_nettype wire

// ----- src/rsw_pcell.sv -----
// ----------------------------------------------------------------------------
// rsw_pcell
// One pending-update slot: mask, target view and ticks left; ages on a
// tick and takes its upper neighbor's entry on removal of it or below.
// ----------------------------------------------------------------------------
`default_nettype none

module rsw_pcell #(
	parameter int MW = 64,
	parameter int VW = 2
) (
	input  wire logic                clk,
	input  wire rsw_pkg::pcell_ctl_t ctl,
	input  wire logic [MW-1:0]       nxt_mask,
	input  wire logic [VW-1:0]       nxt_view,
	input  wire logic [7:0]          nxt_left,
	input  wire logic [MW-1:0]       new_mask,
	input  wire logic [VW-1:0]       new_view,
	input  wire logic [7:0]          new_left,
	output logic      [MW-1:0]       mask,
	output logic      [VW-1:0]       view,
	output logic      [7:0]          left
);

	logic [MW-1:0] mask_q;
	logic [VW-1:0] view_q;
	logic [7:0]    left_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mask_q <= new_mask;
			view_q <= new_view;
			left_q <= new_left;
		end else if (ctl.shift) begin
			mask_q <= nxt_mask;
			view_q <= nxt_view;
			left_q <= nxt_left;
		end else if (ctl.age && left_q != 8'd0) begin
			left_q <= left_q - 8'd1;
		end
	end

	assign mask = mask_q;
	assign view = view_q;
	assign left = left_q;

endmodule

`default_nettype wire

// ----- src/register_scoreboard_wakeup.sv -----
// ----------------------------------------------------------------------------
// register_scoreboard_wakeup
// Register-ready scoreboard with one ready mask per consumer view, delayed
// producer forwarding through a pending queue, and per-view waiter tables.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): one beat is one command: tick,
//    producer ready, broadcast ready, clear, add waiter or cancel waiter.
//  - Output channel (out_valid/out_stall): one beat per wakeup or overflow
//    report; last marks the final beat caused by a command.
//  - Config channel (cfg_valid/cfg_ready): latency row per producer, one
//    byte per consumer; write only while the block is idle.
//  - Sequencing: one command at a time. Clear, empty-mask and unused
//    commands go straight to the finish state; a cancel removes matching
//    waiters one by one. Producer and broadcast updates walk the consumer
//    views in turn, a tick ages pending entries then takes expired ones in
//    turn, and each delivery wakes its waiters one by one. The emit path
//    gives one result per cycle at most and pauses while output is stalled.
//  - Reset clears ready masks, waiter and pending counts and latencies.
//  - A stalled output holds its beat; one further result waits in a hold
//    register, and the sequencer pauses until the output side frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module register_scoreboard_wakeup #(
	parameter int NUM_UNITS        = 4,
	parameter int NUM_REGS         = 64,
	parameter int WAITERS_PER_VIEW = 8,
	parameter int PENDING_DEPTH    = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [2:0]            mode,
	input  wire logic [1:0]            unit,
	input  wire logic [63:0]           reg_mask,
	input  wire logic [15:0]           inst_id,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 kind,
	output logic [1:0]                 view,
	output logic [15:0]                woken_inst_id,
	output logic [63:0]                trigger_mask,
	output logic                       last,
	// configuration channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [7:0]            cfg_index,
	input  wire logic [8*NUM_UNITS-1:0] cfg_data
);

	localparam int VW = $clog2(NUM_UNITS);
	localparam int CW = $clog2(NUM_UNITS + 1);
	localparam int W  = WAITERS_PER_VIEW;
	localparam int WI = (W > 1) ? $clog2(W) : 1;
	localparam int WC = $clog2(W + 1);
	localparam int D  = PENDING_DEPTH;
	localparam int PI = $clog2(D);
	localparam int PC = $clog2(D + 1);
	localparam int LW = 8 * NUM_UNITS;
	localparam int MW = rsw_pkg::MaskW;
	localparam int UW = rsw_pkg::UnitW;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TAGE   = 4'd1;
	localparam logic [3:0] S_TSCAN  = 4'd2;
	localparam logic [3:0] S_PROD   = 4'd3;
	localparam logic [3:0] S_BCAST  = 4'd4;
	localparam logic [3:0] S_DELIV  = 4'd5;
	localparam logic [3:0] S_ADD    = 4'd6;
	localparam logic [3:0] S_CANCEL = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	// sequencer state and the latched command
	logic [3:0]          state_q, nstate;
	logic [2:0]          mode_q;
	logic [VW-1:0]       unit_q;
	logic [NUM_REGS-1:0] bits_q;
	logic [15:0]         id_q;
	logic [CW-1:0]       c_q;
	logic [VW-1:0]       dv_q;
	logic [NUM_REGS-1:0] dbits_q;

	logic [NUM_REGS-1:0] ready_q [NUM_UNITS];
	logic [WC-1:0]       wcnt_q  [NUM_UNITS];
	logic [PC-1:0]       pcnt_q;
	logic [LW-1:0]       lat_q   [NUM_UNITS];

	// result hold stage and output register
	rsw_pkg::res_t hold_q, out_q, gen_res;
	logic          hold_v_q, out_v_q, out_last_q;

	// waiter cell row
	logic [NUM_REGS-1:0] w_need [NUM_UNITS][W];
	logic [15:0]         w_id   [NUM_UNITS][W];
	rsw_pkg::wcell_ctl_t wctl   [NUM_UNITS][W];

	// pending cell row
	logic [NUM_REGS-1:0] p_mask [D];
	logic [VW-1:0]       p_view [D];
	logic [7:0]          p_left [D];
	rsw_pkg::pcell_ctl_t pctl   [D];

	// command decode
	logic [NUM_REGS-1:0] in_bits;
	logic [VW-1:0]       in_uv;
	logic                in_uok;
	logic [VW-1:0]       cv;
	logic                c_end;
	logic [7:0]          lat;

	// search results
	logic [W-1:0] hit, cmatch;
	logic [D-1:0] pz;
	logic [WI-1:0] hit_j, cm_j;
	logic [PI-1:0] pz_j;

	// sequencer actions
	logic                accept, out_free, emit_ok, gen, flush, clr, c_inc;
	logic                dstart;
	logic [VW-1:0]       dstart_v;
	logic [NUM_REGS-1:0] dstart_bits;
	logic                w_rm, w_add;
	logic [VW-1:0]       w_rm_v;
	logic [WI-1:0]       w_rm_j;
	logic                p_rm, p_add, p_age;
	logic [PI-1:0]       p_rm_j;

	assign in_bits  = reg_mask[NUM_REGS-1:0];
	assign in_uv    = VW'(unit);
	assign in_uok   = (CW'(unit) < CW'(NUM_UNITS));
	assign cv       = c_q[VW-1:0];
	assign c_end    = (c_q == CW'(NUM_UNITS));
	assign lat      = lat_q[unit_q][{cv, 3'b000} +: 8];
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_v_q || !out_stall;
	assign emit_ok  = !hold_v_q || out_free;
	assign cfg_ready = 1'b1;

	// Find the first covered waiter of the delivery view, the first id
	// match of the cancel view and the first expired pending entry.
	always_comb begin
		hit    = '0;
		cmatch = '0;
		pz     = '0;
		hit_j  = '0;
		cm_j   = '0;
		pz_j   = '0;
		for (int j = 0; j < W; j++) begin
			hit[j] = (WC'(j) < wcnt_q[dv_q]) &&
				((w_need[dv_q][j] & ~ready_q[dv_q]) == '0);
			cmatch[j] = (WC'(j) < wcnt_q[unit_q]) && (w_id[unit_q][j] == id_q);
		end
		for (int j = 0; j < D; j++) begin
			pz[j] = (PC'(j) < pcnt_q) && (p_left[j] == 8'd0);
		end
		for (int j = W - 1; j >= 0; j--) begin
			if (hit[j]) hit_j = WI'(j);
			if (cmatch[j]) cm_j = WI'(j);
		end
		for (int j = D - 1; j >= 0; j--) begin
			if (pz[j]) pz_j = PI'(j);
		end
	end

	// Sequencer: one command at a time, one result per cycle at most.
	always_comb begin
		nstate      = state_q;
		gen         = 1'b0;
		gen_res     = '0;
		flush       = 1'b0;
		clr         = 1'b0;
		c_inc       = 1'b0;
		dstart      = 1'b0;
		dstart_v    = cv;
		dstart_bits = bits_q;
		w_rm        = 1'b0;
		w_rm_v      = dv_q;
		w_rm_j      = hit_j;
		w_add       = 1'b0;
		p_rm        = 1'b0;
		p_rm_j      = pz_j;
		p_add       = 1'b0;
		p_age       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (mode)
						rsw_pkg::MODE_TICK:   nstate = S_TAGE;
						rsw_pkg::MODE_PROD:   nstate = (in_uok && |in_bits) ? S_PROD : S_FIN;
						rsw_pkg::MODE_BCAST:  nstate = (|in_bits) ? S_BCAST : S_FIN;
						rsw_pkg::MODE_CLEAR: begin
							clr    = 1'b1;
							nstate = S_FIN;
						end
						rsw_pkg::MODE_ADD:    nstate = (in_uok && |in_bits) ? S_ADD : S_FIN;
						rsw_pkg::MODE_CANCEL: nstate = in_uok ? S_CANCEL : S_FIN;
						default:              nstate = S_FIN;
					endcase
				end
			end
			S_TAGE: begin
				p_age  = 1'b1;
				nstate = S_TSCAN;
			end
			S_TSCAN: begin
				if (|pz) begin
					p_rm        = 1'b1;
					dstart      = 1'b1;
					dstart_v    = p_view[pz_j];
					dstart_bits = p_mask[pz_j];
					nstate      = S_DELIV;
				end else begin
					nstate = S_FIN;
				end
			end
			S_PROD: begin
				if (c_end) begin
					nstate = S_FIN;
				end else if (lat == rsw_pkg::LAT_NONE) begin
					c_inc = 1'b1;
				end else if (lat == rsw_pkg::LAT_NOW) begin
					dstart = 1'b1;
					c_inc  = 1'b1;
					nstate = S_DELIV;
				end else if (pcnt_q < PC'(D)) begin
					p_add = 1'b1;
					c_inc = 1'b1;
				end else if (emit_ok) begin
					gen          = 1'b1;
					gen_res.kind = rsw_pkg::KIND_PFULL;
					gen_res.view = UW'(cv);
					gen_res.mask = MW'(bits_q);
					c_inc        = 1'b1;
				end
			end
			S_BCAST: begin
				if (c_end) begin
					nstate = S_FIN;
				end else begin
					dstart = 1'b1;
					c_inc  = 1'b1;
					nstate = S_DELIV;
				end
			end
			S_DELIV: begin
				if (|hit) begin
					if (emit_ok) begin
						gen          = 1'b1;
						gen_res.kind = rsw_pkg::KIND_WAKE;
						gen_res.view = UW'(dv_q);
						gen_res.id   = w_id[dv_q][hit_j];
						gen_res.mask = MW'(dbits_q);
						w_rm         = 1'b1;
					end
				end else if (mode_q == rsw_pkg::MODE_TICK) begin
					nstate = S_TSCAN;
				end else if (mode_q == rsw_pkg::MODE_PROD) begin
					nstate = S_PROD;
				end else begin
					nstate = S_BCAST;
				end
			end
			S_ADD: begin
				if (wcnt_q[unit_q] < WC'(W)) begin
					w_add  = 1'b1;
					nstate = S_FIN;
				end else if (emit_ok) begin
					gen          = 1'b1;
					gen_res.kind = rsw_pkg::KIND_WFULL;
					gen_res.view = UW'(unit_q);
					gen_res.id   = id_q;
					nstate       = S_FIN;
				end
			end
			S_CANCEL: begin
				if (|cmatch) begin
					w_rm   = 1'b1;
					w_rm_v = unit_q;
					w_rm_j = cm_j;
				end else begin
					nstate = S_FIN;
				end
			end
			S_FIN: begin
				if (emit_ok) begin
					flush  = hold_v_q;
					nstate = S_IDLE;
				end
			end
			default: nstate = S_IDLE;
		endcase
	end

	// waiter cells, one compacted row per view
	for (genvar gv = 0; gv < NUM_UNITS; gv++) begin : g_view
		for (genvar gj = 0; gj < W; gj++) begin : g_w
			logic [NUM_REGS-1:0] nxt_need;
			logic [15:0]         nxt_id;
			if (gj == W - 1) begin : g_end
				assign nxt_need = '0;
				assign nxt_id   = '0;
			end else begin : g_mid
				assign nxt_need = w_need[gv][gj+1];
				assign nxt_id   = w_id[gv][gj+1];
			end
			assign wctl[gv][gj].load  = w_add && (unit_q == VW'(gv)) &&
				(wcnt_q[gv] == WC'(gj));
			assign wctl[gv][gj].shift = w_rm && (w_rm_v == VW'(gv)) &&
				(WI'(gj) >= w_rm_j);
			rsw_wcell #(.MW(NUM_REGS)) u_wcell (
				.clk      (clk),
				.ctl      (wctl[gv][gj]),
				.nxt_need (nxt_need),
				.nxt_id   (nxt_id),
				.new_need (bits_q),
				.new_id   (id_q),
				.need     (w_need[gv][gj]),
				.id       (w_id[gv][gj])
			);
		end
	end

	// pending cells, compacted in arrival order
	for (genvar gj = 0; gj < D; gj++) begin : g_p
		logic [NUM_REGS-1:0] nxt_mask;
		logic [VW-1:0]       nxt_view;
		logic [7:0]          nxt_left;
		if (gj == D - 1) begin : g_end
			assign nxt_mask = '0;
			assign nxt_view = '0;
			assign nxt_left = '0;
		end else begin : g_mid
			assign nxt_mask = p_mask[gj+1];
			assign nxt_view = p_view[gj+1];
			assign nxt_left = p_left[gj+1];
		end
		assign pctl[gj].load  = p_add && (pcnt_q == PC'(gj));
		assign pctl[gj].shift = p_rm && (PI'(gj) >= p_rm_j);
		assign pctl[gj].age   = p_age;
		rsw_pcell #(.MW(NUM_REGS), .VW(VW)) u_pcell (
			.clk      (clk),
			.ctl      (pctl[gj]),
			.nxt_mask (nxt_mask),
			.nxt_view (nxt_view),
			.nxt_left (nxt_left),
			.new_mask (bits_q),
			.new_view (cv),
			.new_left (lat),
			.mask     (p_mask[gj]),
			.view     (p_view[gj]),
			.left     (p_left[gj])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pcnt_q   <= '0;
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			c_q      <= '0;
			for (int v = 0; v < NUM_UNITS; v++) begin
				ready_q[v] <= '0;
				wcnt_q[v]  <= '0;
				lat_q[v]   <= '0;
			end
		end else begin
			state_q <= nstate;
			if (accept) c_q <= '0;
			else if (c_inc) c_q <= c_q + CW'(1);
			// latency rows; writes beyond the last producer drop
			if (cfg_valid && cfg_ready && (cfg_index < 8'(NUM_UNITS)))
				lat_q[cfg_index[VW-1:0]] <= cfg_data;
			for (int v = 0; v < NUM_UNITS; v++) begin
				if (clr) ready_q[v] <= ready_q[v] & ~in_bits;
				else if (dstart && dstart_v == VW'(v)) ready_q[v] <= ready_q[v] | dstart_bits;
				if (w_add && unit_q == VW'(v)) wcnt_q[v] <= wcnt_q[v] + WC'(1);
				else if (w_rm && w_rm_v == VW'(v)) wcnt_q[v] <= wcnt_q[v] - WC'(1);
			end
			if (p_add) pcnt_q <= pcnt_q + PC'(1);
			else if (p_rm) pcnt_q <= pcnt_q - PC'(1);
			// output beat: refill from the hold stage, else drop when taken
			if ((gen && hold_v_q) || flush) out_v_q <= 1'b1;
			else if (out_free) out_v_q <= 1'b0;
			if (gen) hold_v_q <= 1'b1;
			else if (flush) hold_v_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			unit_q <= in_uv;
			bits_q <= in_bits;
			id_q   <= inst_id;
		end
		if (dstart) begin
			dv_q    <= dstart_v;
			dbits_q <= dstart_bits;
		end
		if (gen && hold_v_q) begin
			out_q      <= hold_q;
			out_last_q <= 1'b0;
		end else if (flush) begin
			out_q      <= hold_q;
			out_last_q <= 1'b1;
		end
		if (gen) hold_q <= gen_res;
	end

	assign out_valid     = out_v_q;
	assign kind          = out_q.kind;
	assign view          = out_q.view;
	assign woken_inst_id = out_q.id;
	assign trigger_mask  = out_q.mask;
	assign last          = out_last_q;

	`ASSERT_CLK(a_accept_busy, accept |=> (state_q != S_IDLE), "accepted command left sequencer idle")
	`ASSERT_CLK(a_idle_no_hold, (state_q == S_IDLE) |-> !hold_v_q, "held result while idle")
	`ASSERT_NEVER(a_pend_over, pcnt_q > PC'(D), "pending count above depth")
	`ASSERT_NEVER(a_add_rm, (w_add && w_rm) || (p_add && p_rm), "insert and remove together")

endmodule

`default_nettype wire
